### rtl/grsd_pkg.sv
// Package for the grouped running standard deviation unit.
// Holds shared sizes, command and status codes, state machine type and
// controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps
package grsd_pkg;

  localparam int Groups     = 64;
  localparam int GroupBits  = 6;
  localparam int CountBits  = 24;
  localparam int MeanBits   = 48;
  localparam int M2Bits     = 64;
  localparam int SampleBits = 32;

  localparam logic CmdAdd  = 1'b0;
  localparam logic CmdRead = 1'b1;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusUndefined = 2'd1;
  localparam logic [1:0] StatusEmpty     = 2'd2;
  localparam logic [1:0] StatusOverflow  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_DIV1,
    ST_MEAN,
    ST_MUL,
    ST_M2,
    ST_RDIV,
    ST_SQRT,
    ST_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;     // latch the input transaction
    logic load;        // latch entry read data and set up the operation
    logic div_start;   // start the iterative divider
    logic div_step;    // run one divider step
    logic mean_upd;    // apply quotient to the mean
    logic mul;         // accumulate one partial product of the deviations
    logic m2_write;    // fold the increment and write the entry back
    logic rdiv_load;   // set up the read-out division
    logic sqrt_start;  // start the square root
    logic sqrt_step;   // run one square root step
    logic clear;       // clear the entry on read-out
    logic out_load;    // load the result register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_read;
    logic used;
    logic div_done;
    logic mul_done;
    logic sqrt_done;
    logic special;     // read that needs no arithmetic
  } stat_t;

endpackage

### rtl/grsd_datapath.sv
// Datapath of the grouped running standard deviation unit.
// Holds the group table, divider, multiplier and square root unit.
// Depends on grsd_pkg.
`timescale 1ns / 1ps
module grsd_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  grsd_pkg::cmd_t                  ctl,
  output grsd_pkg::stat_t                 sts,
  input  logic                            unbiased,
  input  logic                            cmd,
  input  logic [grsd_pkg::GroupBits-1:0]  group,
  input  logic signed [grsd_pkg::SampleBits-1:0] sample,
  output logic [grsd_pkg::GroupBits-1:0]  group_out,
  output logic [31:0]                     std_dev,
  output logic [1:0]                      status
);

  localparam int CB = grsd_pkg::CountBits;
  localparam int EW = CB + grsd_pkg::MeanBits + grsd_pkg::M2Bits + 1;

  // Entry memory: count, mean, m2, overflow flag.
  logic [EW-1:0] mem [grsd_pkg::Groups];
  logic [grsd_pkg::Groups-1:0] used;
  logic [EW-1:0] rd_data;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  logic                             cmd_r;
  logic [grsd_pkg::GroupBits-1:0]   grp_r;
  logic signed [47:0]               x_r;

  logic [CB-1:0]        cnt;
  logic signed [47:0]   mean;
  logic [63:0]          m2;
  logic                 ovf;

  // Restoring divider: 64-bit dividend, up to CB-bit divisor.
  logic [63:0]          dq;     // dividend shifting into quotient
  logic [CB:0]          drem;
  logic [CB-1:0]        dsor;
  logic [6:0]           dcnt;
  logic                 neg;
  logic [47:0]          mag;

  // The 48 by 48 product is built from four 24 by 24 partial products.
  logic [127:0]         prod;
  logic [2:0]           mcnt;
  logic [23:0]          mul_a;
  logic [23:0]          mul_b;
  logic [47:0]          pp;
  logic [127:0]         pp_shift;

  logic [63:0]          sq_v, sq_res, sq_bit;
  logic                 sq_busy;
  logic [1:0]           spec_st;

  logic [CB:0]          trial;
  logic [63:0]          qmag;
  logic signed [48:0]   d2;
  logic [47:0]          d2mag;
  logic [64:0]          m2sum;
  logic [63:0]          inc;
  logic                 inc_ovf;
  logic [CB-1:0]        div_n;

  always_ff @(posedge clk) begin
    rd_data <= mem[grp_r];
    if (wr_en) begin
      mem[grp_r] <= wr_data;
    end
  end

  assign trial = {drem[CB-1:0], dq[63]} - {1'b0, dsor};
  assign qmag  = dq;
  assign d2    = 49'(x_r) - 49'(mean);
  assign d2mag = d2[48] ? 48'(-d2) : 48'(d2);
  assign inc   = prod[95:32];
  assign inc_ovf = |prod[127:96];
  assign m2sum = {1'b0, m2} + {1'b0, inc};
  assign div_n = unbiased ? cnt - CB'(1) : cnt;

  assign mul_a = mcnt[0] ? mag[47:24] : mag[23:0];
  assign mul_b = mcnt[1] ? d2mag[47:24] : d2mag[23:0];
  assign pp    = mul_a * mul_b;

  always_comb begin
    case (mcnt[1:0])
      2'd0:    pp_shift = {80'd0, pp};
      2'd1:    pp_shift = {56'd0, pp, 24'd0};
      2'd2:    pp_shift = {56'd0, pp, 24'd0};
      2'd3:    pp_shift = {32'd0, pp, 48'd0};
      default: pp_shift = '0;
    endcase
  end

  always_comb begin
    wr_en   = ctl.m2_write;
    wr_data = {cnt, mean,
               (inc_ovf || m2sum[64]) ? {grsd_pkg::M2Bits{1'b1}} : m2sum[63:0],
               ovf | inc_ovf | m2sum[64]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (ctl.m2_write) begin
      used[grp_r] <= 1'b1;
    end else if (ctl.clear) begin
      used[grp_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= cmd;
      grp_r <= group;
      x_r   <= {sample, 16'd0};
    end
    if (ctl.load) begin
      if (!used[grp_r]) begin
        cnt  <= CB'(1);
        mean <= '0;
        m2   <= '0;
        ovf  <= 1'b0;
      end else begin
        {cnt, mean, m2, ovf} <= rd_data;
        if (cmd_r == grsd_pkg::CmdAdd) begin
          if (&rd_data[EW-1 -: CB]) begin
            ovf <= 1'b1;
          end else begin
            cnt <= rd_data[EW-1 -: CB] + CB'(1);
          end
        end
      end
      spec_st <= !used[grp_r] ? grsd_pkg::StatusEmpty :
                 (unbiased && rd_data[EW-1 -: CB] <= CB'(1)) ?
                 grsd_pkg::StatusUndefined :
                 (rd_data[0] ? grsd_pkg::StatusOverflow : grsd_pkg::StatusOk);
    end
    if (ctl.div_start) begin
      neg  <= x_r < mean;
      mag  <= (x_r < mean) ? 48'(mean - x_r) : 48'(x_r - mean);
      dq   <= {16'd0, (x_r < mean) ? 48'(mean - x_r) : 48'(x_r - mean)};
      dsor <= cnt;
      drem <= '0;
      dcnt <= 7'd64;
    end else if (ctl.rdiv_load) begin
      dq   <= m2;
      dsor <= (div_n == '0) ? CB'(1) : div_n;
      drem <= '0;
      dcnt <= 7'd64;
    end else if (ctl.div_step) begin
      if (!trial[CB]) begin
        drem <= trial;
        dq   <= {dq[62:0], 1'b1};
      end else begin
        drem <= {drem[CB-1:0], dq[63]};
        dq   <= {dq[62:0], 1'b0};
      end
      dcnt <= dcnt - 7'd1;
    end
    if (ctl.mean_upd) begin
      mean <= neg ? mean - 48'(qmag) : mean + 48'(qmag);
      prod <= '0;
      mcnt <= 3'd0;
    end
    if (ctl.mul) begin
      prod <= prod + pp_shift;
      mcnt <= mcnt + 3'd1;
    end
    if (rst) begin
      sq_busy <= 1'b0;
    end else if (ctl.sqrt_start) begin
      sq_v    <= dq;
      sq_res  <= '0;
      sq_bit  <= 64'd1 << 62;
      sq_busy <= 1'b1;
    end else if (ctl.sqrt_step) begin
      if (sq_bit == '0) begin
        sq_busy <= 1'b0;
      end else begin
        if (sq_v >= sq_res + sq_bit) begin
          sq_v   <= sq_v - (sq_res + sq_bit);
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
    end
    if (ctl.out_load) begin
      group_out <= grp_r;
      status    <= spec_st;
      std_dev   <= (spec_st == grsd_pkg::StatusEmpty ||
                    spec_st == grsd_pkg::StatusUndefined) ? 32'd0 : sq_res[31:0];
    end
  end

  always_comb begin
    sts.is_read   = cmd_r;
    sts.used      = used[grp_r];
    sts.div_done  = (dcnt == 7'd0);
    sts.mul_done  = (mcnt == 3'd4);
    sts.sqrt_done = !sq_busy || sq_bit == '0;
    sts.special   = (spec_st == grsd_pkg::StatusEmpty ||
                     spec_st == grsd_pkg::StatusUndefined);
  end

  a_write_on_add: assert property (@(posedge clk) disable iff (rst)
    ctl.m2_write |-> cmd_r == grsd_pkg::CmdAdd) else $error("write on read");
  a_used_after_write: assert property (@(posedge clk) disable iff (rst)
    ctl.m2_write |=> used[$past(grp_r)]) else $error("entry not marked used");
  a_div_bounded: assert property (@(posedge clk) disable iff (rst)
    ctl.div_step |-> dcnt != 7'd0) else $error("divider overrun");

endmodule

### rtl/grsd_ctrl.sv
// Controller state machine of the grouped running standard deviation unit.
// Sequences fetch, divide, multiply, write-back and read-out steps.
// Depends on grsd_pkg.
`timescale 1ns / 1ps
module grsd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  grsd_pkg::stat_t sts,
  output grsd_pkg::cmd_t  ctl
);

  grsd_pkg::state_t state, state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= grsd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctl            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      grsd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = grsd_pkg::ST_FETCH;
        end
      end
      grsd_pkg::ST_FETCH: state_next = grsd_pkg::ST_LOAD;
      grsd_pkg::ST_LOAD: begin
        ctl.load = 1'b1;
        if (sts.is_read) begin
          state_next = sts.used ? grsd_pkg::ST_RDIV : grsd_pkg::ST_OUT;
        end else begin
          state_next = grsd_pkg::ST_DIV1;
        end
      end
      grsd_pkg::ST_DIV1: begin
        ctl.div_start = 1'b1;
        state_next    = grsd_pkg::ST_MEAN;
      end
      grsd_pkg::ST_MEAN: begin
        if (sts.div_done) begin
          ctl.mean_upd = 1'b1;
          state_next   = grsd_pkg::ST_MUL;
        end else begin
          ctl.div_step = 1'b1;
        end
      end
      grsd_pkg::ST_MUL: begin
        if (sts.mul_done) begin
          state_next = grsd_pkg::ST_M2;
        end else begin
          ctl.mul = 1'b1;
        end
      end
      grsd_pkg::ST_M2: begin
        ctl.m2_write = 1'b1;
        state_next   = grsd_pkg::ST_IDLE;
      end
      grsd_pkg::ST_RDIV: begin
        ctl.clear = 1'b1;
        if (sts.special) begin
          state_next = grsd_pkg::ST_OUT;
        end else begin
          ctl.rdiv_load = 1'b1;
          state_next    = grsd_pkg::ST_SQRT;
        end
      end
      grsd_pkg::ST_SQRT: begin
        if (!sts.div_done) begin
          ctl.div_step = 1'b1;
        end else begin
          ctl.sqrt_start = 1'b1;
          state_next     = grsd_pkg::ST_OUT;
        end
      end
      grsd_pkg::ST_OUT: begin
        if (!sts.sqrt_done) begin
          ctl.sqrt_step = 1'b1;
        end else if (!out_valid || out_ready) begin
          ctl.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = grsd_pkg::ST_IDLE;
        end
      end
      default: state_next = grsd_pkg::ST_IDLE;
    endcase
  end

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.m2_write, ctl.out_load, ctl.capture})) else $error("op clash");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !out_valid || out_ready) else $error("result overwritten");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == grsd_pkg::ST_IDLE) else $error("ready outside idle");

endmodule

### rtl/grouped_running_std_dev_unit.sv
// Top level of the grouped running standard deviation unit.
// Joins grsd_ctrl and grsd_datapath and holds the configuration register.
// Depends on grsd_pkg, grsd_ctrl and grsd_datapath.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    cmd, group, sample
//   result    out        out_valid / out_ready  group_out, std_dev, status
//   config    in         cfg_we                 cfg_data (unbiased)
//
// An add runs the 64-step divider for the mean and a four-step multiplier.
// A read runs 64 divider steps and 32 square root steps; a read of an empty
// group or an undefined read skips both.
// rst clears the control state and all group-used flags; the table needs no sweep.
// A waiting result blocks only the next read from finishing.
`timescale 1ns / 1ps
module grouped_running_std_dev_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic                                  cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic [grsd_pkg::GroupBits-1:0]        group,
  input  logic signed [grsd_pkg::SampleBits-1:0] sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [grsd_pkg::GroupBits-1:0]        group_out,
  output logic [31:0]                           std_dev,
  output logic [1:0]                            status
);

  grsd_pkg::cmd_t  ctl;
  grsd_pkg::stat_t sts;
  logic            unbiased;

  always_ff @(posedge clk) begin
    if (rst) begin
      unbiased <= 1'b0;
    end else if (cfg_we) begin
      unbiased <= cfg_data;
    end
  end

  grsd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .ctl(ctl)
  );

  grsd_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts), .unbiased(unbiased),
    .cmd(cmd), .group(group), .sample(sample), .group_out(group_out),
    .std_dev(std_dev), .status(status)
  );

endmodule

### verif/tb.sv
// Testbench for grouped_running_std_dev_unit: random and directed add/read traffic,
// with results checked against a Welford-style predictor written here.
// Depends on grsd_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic              op;
    logic [5:0]        grp;
    logic [31:0]       smp;
  } item_t;

  typedef struct packed {
    logic [5:0]  grp;
    logic [31:0] sd;
    logic [1:0]  st;
  } res_t;

  localparam logic [23:0] CountMax = 24'hFFFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [5:0] group = '0;
  logic signed [31:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] group_out;
  logic [31:0] std_dev;
  logic [1:0] status;

  grouped_running_std_dev_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .group(group),
    .sample(sample), .out_valid(out_valid), .out_ready(out_ready),
    .group_out(group_out), .std_dev(std_dev), .status(status)
  );

  always #6 clk = ~clk;

  // Predictor state, one entry per group.
  logic        used_tbl [64];
  logic [23:0] cnt_tbl  [64];
  logic signed [47:0] mean_tbl [64];
  logic [63:0] m2_tbl   [64];
  logic        ovf_tbl  [64];
  logic        div_n1;

  item_t pending_items[$];
  res_t  expected_sd[$];
  int    mismatches = 0;
  int    in_idle_pct = 31;
  int    out_idle_pct = 31;
  bit    out_hold = 1'b0;
  logic  in_ready_seen = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic fold_sample(input logic [5:0] g, input logic [31:0] raw);
    logic signed [63:0] x;
    logic signed [63:0] d1;
    logic signed [63:0] d2;
    logic [63:0] mag1;
    logic [63:0] mag2;
    logic [63:0] q;
    logic [127:0] prod;
    logic [63:0] inc;
    logic [23:0] n;
    logic [64:0] acc;
    x = {{16{raw[31]}}, raw, 16'h0};
    if (!used_tbl[g]) begin
      used_tbl[g] = 1'b1;
      cnt_tbl[g] = 0;
      mean_tbl[g] = 0;
      m2_tbl[g] = 0;
      ovf_tbl[g] = 1'b0;
    end
    n = cnt_tbl[g];
    if (n == CountMax) ovf_tbl[g] = 1'b1;
    else n = n + 1;
    cnt_tbl[g] = n;
    d1 = x - 64'(mean_tbl[g]);
    mag1 = d1 < 0 ? 64'(-d1) : 64'(d1);
    q = mag1 / 64'(n);
    mean_tbl[g] = d1 < 0 ? mean_tbl[g] - 48'(q) : mean_tbl[g] + 48'(q);
    d2 = x - 64'(mean_tbl[g]);
    mag2 = d2 < 0 ? 64'(-d2) : 64'(d2);
    prod = mag1 * mag2;
    if (prod[127:96] != 0) begin
      m2_tbl[g] = '1;
      ovf_tbl[g] = 1'b1;
    end else begin
      inc = prod[95:32];
      acc = {1'b0, m2_tbl[g]} + {1'b0, inc};
      if (acc[64]) begin
        m2_tbl[g] = '1;
        ovf_tbl[g] = 1'b1;
      end else begin
        m2_tbl[g] = acc[63:0];
      end
    end
  endtask

  task automatic predict(input item_t it);
    res_t r;
    logic [63:0] dv;
    if (it.op == grsd_pkg::CmdAdd) begin
      fold_sample(it.grp, it.smp);
      return;
    end
    r.grp = it.grp;
    r.sd = 0;
    if (!used_tbl[it.grp]) begin
      r.st = grsd_pkg::StatusEmpty;
    end else begin
      if (div_n1 && cnt_tbl[it.grp] <= 1) begin
        r.st = grsd_pkg::StatusUndefined;
      end else begin
        dv = div_n1 ? 64'(cnt_tbl[it.grp]) - 1 : 64'(cnt_tbl[it.grp]);
        if (dv == 0) dv = 1;
        r.sd = 32'(int_sqrt(m2_tbl[it.grp] / dv));
        r.st = ovf_tbl[it.grp] ? grsd_pkg::StatusOverflow : grsd_pkg::StatusOk;
      end
      used_tbl[it.grp] = 1'b0;
    end
    expected_sd.push_back(r);
  endtask

  // Driver: presents items at the falling edge; prediction happens on acceptance.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          item_t it;
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          cmd <= it.op;
          group <= it.grp;
          sample <= it.smp;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !out_hold && ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    in_ready_seen <= 1'b0;
    if (!rst && in_valid && in_ready) begin
      in_ready_seen <= 1'b1;
      predict('{op: cmd, grp: group, smp: sample});
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_sd.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        res_t e;
        e = expected_sd.pop_front();
        if (group_out !== e.grp)
          report_mismatch($sformatf("group_out %0d, expected %0d", group_out, e.grp));
        if (std_dev !== e.sd)
          report_mismatch($sformatf("group %0d std_dev %h, expected %h", e.grp, std_dev, e.sd));
        if (status !== e.st)
          report_mismatch($sformatf("group %0d status %0d, expected %0d", e.grp, status, e.st));
      end
    end
  end

  function automatic item_t mk(input logic op, input logic [5:0] g, input logic [31:0] s);
    item_t it;
    it.op = op;
    it.grp = g;
    it.smp = s;
    return it;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'($urandom_range(2000)) - 32'd1000;
      default: return 32'($urandom_range(32'h000A0000)) - 32'h00050000;
    endcase
  endfunction

  // Waits until the pending queue and all expected results are drained.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_sd.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_mode(input logic v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    div_n1 = v;
  endtask

  task automatic random_phase(input int n);
    logic [5:0] g;
    int k;
    for (int i = 0; i < n; ) begin
      g = $urandom_range(7) == 0 ? 6'($urandom_range(63)) : 6'($urandom_range(7));
      if ($urandom_range(9) < 8) begin
        k = $urandom_range(5);
        for (int j = 0; j < k; j++)
          pending_items.push_back(mk(grsd_pkg::CmdAdd, g, rand_sample()));
        pending_items.push_back(mk(grsd_pkg::CmdRead, g, $urandom()));
        i += k + 1;
      end else begin
        pending_items.push_back(mk(1'($urandom_range(1)), g, rand_sample()));
        i++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 64; i++) used_tbl[i] = 1'b0;
    div_n1 = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty read, single sample, extremes, undefined case.
    pending_items.push_back(mk(grsd_pkg::CmdRead, 6'd0, 32'h0));
    pending_items.push_back(mk(grsd_pkg::CmdAdd, 6'd63, 32'h7FFFFFFF));
    pending_items.push_back(mk(grsd_pkg::CmdAdd, 6'd63, 32'h80000000));
    pending_items.push_back(mk(grsd_pkg::CmdAdd, 6'd63, 32'h7FFFFFFF));
    pending_items.push_back(mk(grsd_pkg::CmdRead, 6'd63, 32'hFFFFFFFF));
    pending_items.push_back(mk(grsd_pkg::CmdAdd, 6'd1, 32'h00010000));
    pending_items.push_back(mk(grsd_pkg::CmdRead, 6'd1, 32'h0));
    pending_items.push_back(mk(grsd_pkg::CmdAdd, 6'd2, 32'hFFFF0000));
    pending_items.push_back(mk(grsd_pkg::CmdAdd, 6'd2, 32'h00030000));
    pending_items.push_back(mk(grsd_pkg::CmdAdd, 6'd2, 32'h00000001));
    pending_items.push_back(mk(grsd_pkg::CmdRead, 6'd2, 32'h0));
    pending_items.push_back(mk(grsd_pkg::CmdRead, 6'd2, 32'h0));
    drain();
    set_mode(1'b1);
    pending_items.push_back(mk(grsd_pkg::CmdRead, 6'd5, 32'h0));
    pending_items.push_back(mk(grsd_pkg::CmdAdd, 6'd5, 32'h12345678));
    pending_items.push_back(mk(grsd_pkg::CmdRead, 6'd5, 32'h0));
    pending_items.push_back(mk(grsd_pkg::CmdAdd, 6'd6, 32'h80000000));
    pending_items.push_back(mk(grsd_pkg::CmdAdd, 6'd6, 32'h7FFFFFFF));
    pending_items.push_back(mk(grsd_pkg::CmdAdd, 6'd6, 32'h00000000));
    pending_items.push_back(mk(grsd_pkg::CmdRead, 6'd6, 32'h0));
    drain();

    // Long stretch with no idling.
    in_idle_pct = 0;
    out_idle_pct = 0;
    random_phase(200);
    drain();
    in_idle_pct = 31;
    out_idle_pct = 31;

    set_mode(1'b0);
    random_phase(300);
    // Receiver holds off while the sender keeps offering items.
    out_hold = 1'b1;
    for (int c = 0; c < 3000; c++) @(posedge clk);
    out_hold = 1'b0;
    drain();

    set_mode(1'b1);
    random_phase(350);
    drain();
    set_mode(1'b0);
    random_phase(330);
    drain();

    if (mismatches == 0) $display("** grouped_running_std_dev_unit: PASSED **");
    else $display("** grouped_running_std_dev_unit: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("** grouped_running_std_dev_unit: FAILED **");
    $finish;
  end
endmodule

### grouped_running_std_dev_unit.f
rtl/grsd_pkg.sv
rtl/grsd_datapath.sv
rtl/grsd_ctrl.sv
rtl/grouped_running_std_dev_unit.sv
verif/tb.sv
